[rtl/core/htfd_pkg.sv]
// htfd_pkg: shared types, constants and functions of the humidity and
// temperature frame decoder (crc-8 step, divide-by-65535 rounding, status codes).
// Depends on nothing; imported by htfd_frame and humidity_temp_frame_decoder.
`default_nettype none

package htfd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned WORD_W   = 16;
   localparam int unsigned POS_W    = 3;
   localparam int unsigned NUM_W    = 32;
   localparam int unsigned TC_W     = 15;
   localparam int unsigned TF_W     = 16;
   localparam int unsigned HUM_W    = 14;
   localparam int unsigned STATUS_W = 2;

   // byte positions inside a frame
   localparam logic [POS_W-1:0] POS_T_HI  = 3'd0;
   localparam logic [POS_W-1:0] POS_T_LO  = 3'd1;
   localparam logic [POS_W-1:0] POS_T_CRC = 3'd2;
   localparam logic [POS_W-1:0] POS_H_HI  = 3'd3;
   localparam logic [POS_W-1:0] POS_H_LO  = 3'd4;
   localparam logic [POS_W-1:0] POS_H_CRC = 3'd5;

   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
   localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

   // conversion spans and offsets, all in hundredths
   localparam logic [WORD_W-1:0] SPAN_C    = 16'd17500;
   localparam logic [WORD_W-1:0] SPAN_F    = 16'd31500;
   localparam logic [WORD_W-1:0] SPAN_H    = 16'd10000;
   localparam logic [WORD_W-1:0] OFFSET_C  = 16'd4500;
   localparam logic [WORD_W-1:0] OFFSET_F  = 16'd4900;
   localparam logic [HUM_W-1:0]  HUM_MAX   = 14'd10000;
   localparam logic [NUM_W-1:0]  ROUND_ADD = 32'd32767;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_TEMP_CRC = 2'd1,
      STATUS_HUM_CRC  = 2'd2
   } status_type;

   // one completed frame, as handed from the frame tracker
   typedef struct packed {
      logic               done;
      status_type         status;
      logic [WORD_W-1:0]  raw_t;
      logic [WORD_W-1:0]  raw_h;
   } frame_type;

   // crc-8, msb first, one byte
   function automatic logic [BYTE_W-1:0] crc_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] c;
      c = crc ^ b;
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

   // floor(num / 65535): 65536 * q0 + lo = 65535 * q0 + (lo + q0), then fix up
   function automatic logic [WORD_W-1:0] div_65535(input logic [NUM_W-1:0] num);
      logic [WORD_W-1:0] q0;
      logic [WORD_W:0]   r0;
      logic [WORD_W-1:0] q;
      q0 = num[NUM_W-1:WORD_W];
      r0 = {1'b0, num[WORD_W-1:0]} + {1'b0, q0};
      if (r0 >= 17'd131070) begin
         q = q0 + 16'd2;
      end else if (r0 >= 17'd65535) begin
         q = q0 + 16'd1;
      end else begin
         q = q0;
      end
      return q;
   endfunction

endpackage

`default_nettype wire

[rtl/core/htfd_frame.sv]
// htfd_frame: tracks the byte position of a six-byte frame, runs the crc-8
// over each word and collects the raw words; flags the last byte of a frame.
// Depends on htfd_pkg.
`default_nettype none

module htfd_frame (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [htfd_pkg::BYTE_W-1:0]   rx_byte,
   input  logic                          frame_start,
   output htfd_pkg::frame_type           frame
);
   import htfd_pkg::*;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] crc_ff, crc_in;
   logic [WORD_W-1:0] temp_word_ff, temp_word_in;
   logic [WORD_W-1:0] hum_word_ff, hum_word_in;
   logic              temp_good_ff, temp_good_in;

   logic [POS_W-1:0]  pos;
   logic [BYTE_W-1:0] crc_next;
   logic              hum_good;

   always_comb begin
      // positions past the end restart the frame
      if (frame_start || pos_ff > POS_H_CRC) begin
         pos = POS_T_HI;
      end else begin
         pos = pos_ff;
      end
      if (pos == POS_T_HI || pos == POS_H_HI) begin
         crc_next = crc_update(CRC_INIT, rx_byte);
      end else begin
         crc_next = crc_update(crc_ff, rx_byte);
      end
      hum_good = (crc_ff == rx_byte);

      pos_in       = pos_ff;
      crc_in       = crc_ff;
      temp_word_in = temp_word_ff;
      hum_word_in  = hum_word_ff;
      temp_good_in = temp_good_ff;
      frame        = '{done: 1'b0, status: STATUS_OK, raw_t: temp_word_ff,
                       raw_h: hum_word_ff};

      if (step) begin
         pos_in = (pos >= POS_H_CRC) ? POS_T_HI : pos + 3'd1;
         unique case (pos)
            POS_T_HI: begin
               temp_word_in = {rx_byte, temp_word_ff[BYTE_W-1:0]};
               crc_in       = crc_next;
            end
            POS_T_LO: begin
               temp_word_in = {temp_word_ff[WORD_W-1:BYTE_W], rx_byte};
               crc_in       = crc_next;
            end
            POS_T_CRC: begin
               temp_good_in = (crc_ff == rx_byte);
               crc_in       = CRC_INIT;
            end
            POS_H_HI: begin
               hum_word_in = {rx_byte, hum_word_ff[BYTE_W-1:0]};
               crc_in      = crc_next;
            end
            POS_H_LO: begin
               hum_word_in = {hum_word_ff[WORD_W-1:BYTE_W], rx_byte};
               crc_in      = crc_next;
            end
            default: begin
               frame.done = 1'b1;
               if (!temp_good_ff) begin
                  frame.status = STATUS_TEMP_CRC;
               end else if (!hum_good) begin
                  frame.status = STATUS_HUM_CRC;
               end else begin
                  frame.status = STATUS_OK;
               end
               crc_in = CRC_INIT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_T_HI;
         crc_ff       <= CRC_INIT;
         temp_word_ff <= '0;
         hum_word_ff  <= '0;
         temp_good_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         temp_word_ff <= temp_word_in;
         hum_word_ff  <= hum_word_in;
         temp_good_ff <= temp_good_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/humidity_temp_frame_decoder.sv]
// humidity_temp_frame_decoder: top level of the measurement frame decoder,
// with input register, scaling stage and output register.
// Depends on htfd_pkg and htfd_frame.
//
// usage
//   req channel: one received byte per request, in frame order: temperature
//   high, temperature low, temperature crc, humidity high, humidity low,
//   humidity crc. req_tuser marks the first byte of a frame and restarts the
//   byte position and crc; an unmarked byte after a full frame starts a new one.
//   rsp channel: one response per six-byte frame, issued on the humidity crc
//   byte, carrying status, raw words and converted values in hundredths.
//   path: the last byte of a frame and its response pass the input register,
//   product register and output register in that order.
//   throughput: one byte per cycle, sustained, while rsp_tready stays high.
//   stall: when the receiver holds rsp_tready low the stages behind the output
//   register fill one at a time; bytes that cause no response still pass
//   until a pending response blocks the product stage, then req_tready drops.
//   reset: synchronous, clears the pipeline valids, byte position and crc.
`default_nettype none

module humidity_temp_frame_decoder (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] frame_start
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata    // [1:0] frame_status, [16:2] temp_c_centi,
                                    // [32:17] temp_f_centi, [46:33] humidity_centi,
                                    // [62:47] raw_temperature, [78:63] raw_humidity,
                                    // [79] reading_valid
);
   import htfd_pkg::*;

   // product stage contents
   typedef struct packed {
      status_type        status;
      logic [WORD_W-1:0] raw_t;
      logic [WORD_W-1:0] raw_h;
      logic [NUM_W-1:0]  num_c;
      logic [NUM_W-1:0]  num_f;
      logic [NUM_W-1:0]  num_h;
   } mid_type;

   typedef struct packed {
      logic              reading_valid;
      logic [WORD_W-1:0] raw_h;
      logic [WORD_W-1:0] raw_t;
      logic [HUM_W-1:0]  hum;
      logic [TF_W-1:0]   tf;
      logic [TC_W-1:0]   tc;
      status_type        status;
   } rsp_type;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic              in_start_ff, in_start_in;

   // product register
   logic              mid_valid_ff, mid_valid_in;
   mid_type           mid_ff, mid_in;

   // output register
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   logic              out_free, mid_free, step;
   frame_type         frame;

   logic [WORD_W-1:0] q_c, q_f, q_h;
   logic [WORD_W:0]   tc_wide, tf_wide;

   // stage handshakes: each stage moves when the one after it has room
   assign out_free   = !out_valid_ff || rsp_tready;
   assign mid_free   = !mid_valid_ff || out_free;
   assign step       = in_valid_ff && mid_free;
   assign req_tready = !in_valid_ff || mid_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_start_in = in_start_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
         in_start_in = req_tuser;
      end
   end

   htfd_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .rx_byte     (in_byte_ff),
      .frame_start (in_start_ff),
      .frame       (frame)
   );

   // scaled numerators span * raw + half divisor, from the held raw words
   always_comb begin
      mid_valid_in = mid_valid_ff;
      mid_in       = mid_ff;
      if (mid_free) begin
         mid_valid_in  = step && frame.done;
         mid_in.status = frame.status;
         mid_in.raw_t  = frame.raw_t;
         mid_in.raw_h  = frame.raw_h;
         mid_in.num_c  = NUM_W'(SPAN_C) * NUM_W'(frame.raw_t) + ROUND_ADD;
         mid_in.num_f  = NUM_W'(SPAN_F) * NUM_W'(frame.raw_t) + ROUND_ADD;
         mid_in.num_h  = NUM_W'(SPAN_H) * NUM_W'(frame.raw_h) + ROUND_ADD;
      end
   end

   // divide by 65535, apply offsets, clamp humidity; zeros on crc error
   always_comb begin
      q_c     = div_65535(mid_ff.num_c);
      q_f     = div_65535(mid_ff.num_f);
      q_h     = div_65535(mid_ff.num_h);
      tc_wide = {1'b0, q_c} - {1'b0, OFFSET_C};
      tf_wide = {1'b0, q_f} - {1'b0, OFFSET_F};

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_free) begin
         out_valid_in         = mid_valid_ff;
         out_in.status        = mid_ff.status;
         out_in.raw_t         = mid_ff.raw_t;
         out_in.raw_h         = mid_ff.raw_h;
         out_in.reading_valid = (mid_ff.status == STATUS_OK);
         if (mid_ff.status == STATUS_OK) begin
            out_in.tc  = tc_wide[TC_W-1:0];
            out_in.tf  = tf_wide[TF_W-1:0];
            out_in.hum = (q_h > {2'b00, HUM_MAX}) ? HUM_MAX : q_h[HUM_W-1:0];
         end else begin
            out_in.tc  = '0;
            out_in.tf  = '0;
            out_in.hum = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_start_ff <= in_start_in;
      mid_ff      <= mid_in;
      out_ff      <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

`ifndef SYNTHESIS
   // reading_valid tracks the status code
   a_valid_matches_status: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.reading_valid == (out_ff.status == STATUS_OK)))
      else $error("reading_valid disagrees with frame_status");

   // converted values are zero on any crc error
   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.status != STATUS_OK) |->
      (out_ff.tc == '0 && out_ff.tf == '0 && out_ff.hum == '0))
      else $error("nonzero converted value on crc error");

   // humidity never exceeds full scale
   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.hum <= HUM_MAX))
      else $error("humidity above full scale");

   // a pending product entry is not dropped while the output is blocked
   a_mid_held: assert property (@(posedge clock) disable iff (reset)
      (mid_valid_ff && !out_free) |=> (mid_valid_ff && $stable(mid_ff)))
      else $error("product stage lost an entry under stall");

   // no byte is consumed while the product stage is blocked
   a_no_step_blocked: assert property (@(posedge clock) disable iff (reset)
      !mid_free |-> !step)
      else $error("frame tracker advanced while blocked");
`endif

endmodule

`default_nettype wire
